/* rtl/core/tepq_pkg.sv */
// ----------------------------------------------------------------------------
// tepq_pkg
// Shared types and constants of the timed event priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tepq_pkg;

    localparam int ID_W     = 4;
    localparam int TIME_W   = 32;
    localparam int PRIO_W   = 8;
    localparam int CIL_W    = 10;
    localparam int ID_COUNT = 16;

    localparam int EVENT_SLOTS_DEF     = 16;
    localparam int CYCLES_PER_LINE_DEF = 228;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_RUN    = 2'd3
    } op_t;

    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] due;
        logic [ID_W-1:0]   id;
    } entry_t;

    // handshake between the sequencer and the divider
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
    } div_req_t;

endpackage

`default_nettype wire

/* rtl/core/tepq_ram.sv */
// ----------------------------------------------------------------------------
// tepq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tepq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/tepq_div.sv */
// ----------------------------------------------------------------------------
// tepq_div
// Division by a constant through a reciprocal multiply and a short fix-up.
// ----------------------------------------------------------------------------
`default_nettype none

module tepq_div
    import tepq_pkg::*;
#(
    parameter int DIVISOR = CYCLES_PER_LINE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_req_t          req,
    output logic                   busy,
    output logic [TIME_W-1:0]      quotient,
    output logic [CIL_W-1:0]       remainder
);

    localparam int PW = 2 * TIME_W;
    // remainder estimate stays below three divisors, so below 3 * 1024
    localparam int RW = CIL_W + 2;
    localparam logic [TIME_W-1:0] RECIP =
        TIME_W'(((64'd1 << TIME_W) - 64'd1) / 64'(DIVISOR));
    localparam logic [RW-1:0] DIV_R  = RW'(DIVISOR);
    localparam logic [RW-1:0] DIV2_R = RW'(2 * DIVISOR);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_BACK,
        DV_FIX
    } div_state_t;

    div_state_t        state_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] q_reg;
    logic [RW-1:0]     r_reg;
    logic [PW-1:0]     prod;
    logic [RW-1:0]     r_est;

    assign prod  = PW'(t_reg) * PW'(RECIP);
    // only the low bits matter since the true remainder is small
    assign r_est = t_reg[RW-1:0] - q_reg[RW-1:0] * DIV_R;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            t_reg     <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
        end
        else if (req.start)
        begin
            state_reg <= DV_MUL;
            t_reg     <= req.dividend;
        end
        else
        begin
            case (state_reg)
                DV_MUL:
                begin
                    // estimate falls short of the quotient by at most two
                    q_reg     <= prod[PW-1:TIME_W];
                    state_reg <= DV_BACK;
                end
                DV_BACK:
                begin
                    r_reg     <= r_est;
                    state_reg <= DV_FIX;
                end
                DV_FIX:
                begin
                    if (r_reg >= DIV2_R)
                    begin
                        q_reg <= q_reg + TIME_W'(2);
                        r_reg <= r_reg - DIV2_R;
                    end
                    else if (r_reg >= DIV_R)
                    begin
                        q_reg <= q_reg + TIME_W'(1);
                        r_reg <= r_reg - DIV_R;
                    end
                    state_reg <= DV_IDLE;
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != DV_IDLE);
    assign quotient  = q_reg;
    assign remainder = r_reg[CIL_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/timed_event_priority_queue.sv */
// ----------------------------------------------------------------------------
// timed_event_priority_queue
// Sorted event queue in a circular RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
// clear is done in the idle state; remove reads and checks every queued entry;
//   insert reads and shifts each entry it moves past; both walk the single RAM
//   port pair. run: reads the head, then the shared divider multiplies, checks
//   back and fixes up, then the output register is loaded, for every result
//   and the closing marker; a full output register stalls the run
// one transaction in flight at a time, input is not ready until it finishes
// reset clears the entry count, the id flags and the head pointer; the RAM
//   itself is not cleared
`default_nettype none

module timed_event_priority_queue
    import tepq_pkg::*;
#(
    parameter int EVENT_SLOTS     = EVENT_SLOTS_DEF,
    parameter int CYCLES_PER_LINE = CYCLES_PER_LINE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // event_id[3:0], due_time[35:4], event_priority[43:36], until_time[75:44]
    input  wire logic [79:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // fired_id[3:0], line[35:4], cycle_in_line[45:36]
    output logic [47:0]      m_axis_tdata,
    // kind[0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    // one entry per identifier at most
    localparam int DEPTH = (EVENT_SLOTS < ID_COUNT) ? EVENT_SLOTS : ID_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = AW + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RM_RD,
        ST_RM_CHK,
        ST_INS_RD,
        ST_INS_CHK,
        ST_RUN_RD,
        ST_RUN_CHK,
        ST_DIV_WAIT
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       k_reg;
    logic [AW-1:0]       head_reg;
    logic [ID_COUNT-1:0] flags_reg;
    logic                found_reg;
    logic                marker_reg;
    op_t                 op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [TIME_W-1:0]   due_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic [TIME_W-1:0]   until_reg;
    logic [ID_W-1:0]     fid_reg;

    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [TIME_W-1:0]   out_line_reg;
    logic [CIL_W-1:0]    out_cil_reg;
    logic                out_last_reg;

    op_t               in_op;
    logic [ID_W-1:0]   in_id;
    logic [TIME_W-1:0] in_due;
    logic [PRIO_W-1:0] in_prio;
    logic [TIME_W-1:0] in_until;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t        rd_entry;
    entry_t        new_entry;

    div_req_t          div_req;
    logic              div_busy;
    logic [TIME_W-1:0] div_quot;
    logic [CIL_W-1:0]  div_rem;

    logic in_fire;
    logic out_free;
    logic out_load;
    logic precedes;
    logic is_due;

    // logical position to RAM address, wrapping around the head
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(pos);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign in_op    = op_t'(s_axis_tuser);
    assign in_id    = s_axis_tdata[3:0];
    assign in_due   = s_axis_tdata[35:4];
    assign in_prio  = s_axis_tdata[43:36];
    assign in_until = s_axis_tdata[75:44];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_DIV_WAIT) && !div_busy && out_free;

    assign rd_entry  = ram_rdata;
    assign new_entry = '{prio: prio_reg, due: due_reg, id: id_reg};
    assign precedes  = (due_reg < rd_entry.due) ||
                       ((due_reg == rd_entry.due) && (prio_reg > rd_entry.prio));
    assign is_due    = (rd_entry.due <= until_reg);

    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = phys(head_reg, k_reg);
        ram_wdata    = new_entry;
        ram_raddr    = phys(head_reg, k_reg);
        div_req      = '{start: 1'b0, dividend: until_reg};
        case (state_reg)
            ST_RM_CHK:
            begin
                // close the gap left by the removed entry
                ram_we    = found_reg;
                ram_waddr = phys(head_reg, k_reg - 1'b1);
                ram_wdata = rd_entry;
            end
            ST_INS_RD:
            begin
                ram_raddr = phys(head_reg, k_reg - 1'b1);
                ram_we    = (k_reg == '0);
            end
            ST_INS_CHK:
            begin
                ram_we    = 1'b1;
                ram_wdata = precedes ? rd_entry : new_entry;
            end
            ST_RUN_RD:
            begin
                ram_raddr     = head_reg;
                div_req.start = (count_reg == '0);
            end
            ST_RUN_CHK:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = is_due ? rd_entry.due : until_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            head_reg      <= '0;
            flags_reg     <= '0;
            found_reg     <= 1'b0;
            marker_reg    <= 1'b0;
            op_reg        <= OP_CLEAR;
            id_reg        <= '0;
            due_reg       <= '0;
            prio_reg      <= '0;
            until_reg     <= '0;
            fid_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_EVENT;
            out_id_reg    <= '0;
            out_line_reg  <= '0;
            out_cil_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg    <= in_op;
                        id_reg    <= in_id;
                        due_reg   <= in_due;
                        prio_reg  <= in_prio;
                        until_reg <= in_until;
                        case (in_op)
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                flags_reg <= '0;
                            end
                            OP_INSERT, OP_REMOVE:
                            begin
                                if (flags_reg[in_id])
                                begin
                                    k_reg     <= '0;
                                    found_reg <= 1'b0;
                                    state_reg <= ST_RM_RD;
                                end
                                else if ((in_op == OP_INSERT) &&
                                         (count_reg < CW'(DEPTH)))
                                begin
                                    k_reg     <= count_reg;
                                    state_reg <= ST_INS_RD;
                                end
                            end
                            OP_RUN:
                            begin
                                state_reg <= ST_RUN_RD;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_RM_RD:
                begin
                    if (k_reg == count_reg)
                    begin
                        count_reg         <= count_reg - 1'b1;
                        flags_reg[id_reg] <= 1'b0;
                        if (op_reg == OP_INSERT)
                        begin
                            k_reg     <= count_reg - 1'b1;
                            state_reg <= ST_INS_RD;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_RM_CHK;
                    end
                end
                ST_RM_CHK:
                begin
                    if (!found_reg && (rd_entry.id == id_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= ST_RM_RD;
                end
                ST_INS_RD:
                begin
                    if (k_reg == '0)
                    begin
                        count_reg         <= count_reg + 1'b1;
                        flags_reg[id_reg] <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_INS_CHK;
                    end
                end
                ST_INS_CHK:
                begin
                    if (precedes)
                    begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= ST_INS_RD;
                    end
                    else
                    begin
                        count_reg         <= count_reg + 1'b1;
                        flags_reg[id_reg] <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                end
                ST_RUN_RD:
                begin
                    if (count_reg == '0)
                    begin
                        marker_reg <= 1'b1;
                        state_reg  <= ST_DIV_WAIT;
                    end
                    else
                    begin
                        state_reg <= ST_RUN_CHK;
                    end
                end
                ST_RUN_CHK:
                begin
                    if (is_due)
                    begin
                        // pop the head entry
                        head_reg <= (head_reg == AW'(DEPTH - 1)) ? '0 :
                                    head_reg + 1'b1;
                        count_reg               <= count_reg - 1'b1;
                        flags_reg[rd_entry.id]  <= 1'b0;
                        fid_reg                 <= rd_entry.id;
                        marker_reg              <= 1'b0;
                    end
                    else
                    begin
                        marker_reg <= 1'b1;
                    end
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (!div_busy && out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= marker_reg ? KIND_MARKER : KIND_EVENT;
                        out_id_reg    <= marker_reg ? '0 : fid_reg;
                        out_line_reg  <= div_quot;
                        out_cil_reg   <= div_rem;
                        out_last_reg  <= marker_reg;
                        state_reg     <= marker_reg ? ST_IDLE : ST_RUN_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    tepq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tepq_div #(
        .DIVISOR (CYCLES_PER_LINE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_cil_reg, out_line_reg, out_id_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond storage depth");

    a_flags_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(flags_reg) == int'(count_reg))
        else $error("id flags disagree with entry count");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_kind_reg == out_last_reg))
        else $error("marker and last flag out of step");

endmodule

`default_nettype wire
